>>> hw/rtl/ntft_pkg.sv
// Shared constants and types for the nearest-timestamp frame table.
`default_nettype none

package ntft_pkg;

    localparam int TABLE_DEPTH = 1024;
    localparam int TIME_BITS   = 32;
    localparam int IDX_W       = $clog2(TABLE_DEPTH);
    localparam int CNT_W       = IDX_W + 1;

    typedef enum logic [1:0] {
        CMD_APPEND = 2'd0,
        CMD_CLEAR  = 2'd1,
        CMD_TIME   = 2'd2,
        CMD_INDEX  = 2'd3
    } t_cmd;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_NOT_FOUND = 2'd1,
        ST_FULL      = 2'd2
    } t_status;

endpackage

`default_nettype wire

>>> hw/rtl/ntft_if.sv
// Request and response channel interfaces of the frame table.
`default_nettype none

interface ntft_req_if import ntft_pkg::*; ();
    logic                 valid;
    logic                 ready;
    logic [1:0]           command;
    logic [TIME_BITS-1:0] time_value;
    logic [IDX_W-1:0]     entry_index;

    modport source (output valid, output command, output time_value,
                    output entry_index, input ready);
    modport sink   (input valid, input command, input time_value,
                    input entry_index, output ready);
endinterface

interface ntft_rsp_if import ntft_pkg::*; ();
    logic                 valid;
    logic                 ready;
    logic [1:0]           status;
    logic [IDX_W-1:0]     found_index;
    logic [TIME_BITS-1:0] found_time;
    logic [CNT_W-1:0]     entry_count;
    logic [TIME_BITS-1:0] duration;

    modport source (output valid, output status, output found_index,
                    output found_time, output entry_count, output duration,
                    input ready);
    modport sink   (input valid, input status, input found_index,
                    input found_time, input entry_count, input duration,
                    output ready);
endinterface

`default_nettype wire

>>> hw/rtl/ntft_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module ntft_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write port and registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

>>> hw/rtl/nearest_timestamp_frame_table_top.sv
// Top level of the nearest-timestamp frame table.
//
// Timestamps are kept in one 1024 x 32 RAM with a registered read; the entry
// count and the first and last timestamps live in registers. One command is
// processed at a time; every command ends in a staging step that moves its
// result into the output register as soon as that register is free, and a
// new request is taken right after that step has run, even if the previous
// result still waits downstream. Append and clear go straight to staging, an
// index lookup reads its entry first. A time lookup that clamps to the first
// or last entry goes straight to staging; otherwise the binary search issues
// one RAM read per cycle, then reads the selected entry and, unless it is the
// first, its earlier neighbour, compares the distances and stages the result.
// The staging step waits while the output register stays occupied.
// The table comes out of reset empty; the RAM needs no clearing pass because
// only read data from slots below the count is used.
`default_nettype none

module nearest_timestamp_frame_table_top
    import ntft_pkg::*;
(
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    ntft_req_if.sink   i_req,
    ntft_rsp_if.source o_rsp
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_IDX,
        S_SRCH,
        S_SEL,
        S_PREV,
        S_PICK,
        S_DONE
    } t_state;

    t_state               r_state;
    logic [CNT_W-1:0]     r_count;
    logic [TIME_BITS-1:0] r_first;
    logic [TIME_BITS-1:0] r_last;
    logic [TIME_BITS-1:0] r_q;
    logic [CNT_W-1:0]     r_lo;
    logic [CNT_W-1:0]     r_hi;
    logic [IDX_W-1:0]     r_mid;
    logic [IDX_W-1:0]     r_sel;
    logic [TIME_BITS-1:0] r_tsel;
    logic [TIME_BITS-1:0] r_tprev;
    logic [TIME_BITS-1:0] r_dsel;
    logic [TIME_BITS-1:0] r_dprev;

    // staged result of the current command
    t_status              r_st_status;
    logic [IDX_W-1:0]     r_st_idx;
    logic [TIME_BITS-1:0] r_st_time;

    // output register
    logic                 r_o_valid;
    t_status              r_o_status;
    logic [IDX_W-1:0]     r_o_idx;
    logic [TIME_BITS-1:0] r_o_time;
    logic [CNT_W-1:0]     r_o_count;
    logic [TIME_BITS-1:0] r_o_dur;

    logic                 ram_we;
    logic [IDX_W-1:0]     ram_raddr;
    logic [TIME_BITS-1:0] ram_rdata;

    logic                 req_xfer;
    t_cmd                 req_cmd;
    logic                 tbl_full;
    logic                 out_free;
    logic                 rsp_load;

    logic                 srch_right;
    logic [CNT_W-1:0]     n_lo;
    logic [CNT_W-1:0]     n_hi;
    logic [CNT_W-1:0]     srch_mid;
    logic                 srch_more;
    logic [IDX_W-1:0]     srch_sel;

    assign i_req.ready = (r_state == S_IDLE);
    assign req_xfer    = i_req.valid && i_req.ready;
    assign req_cmd     = t_cmd'(i_req.command);
    assign tbl_full    = (r_count >= CNT_W'(TABLE_DEPTH));
    assign out_free    = !r_o_valid || o_rsp.ready;
    assign rsp_load    = (r_state == S_DONE) && out_free;

    // one binary search step on the probe just read
    always_comb begin
        srch_right = (ram_rdata < r_q);
        n_lo       = srch_right ? ({1'b0, r_mid} + CNT_W'(1)) : r_lo;
        n_hi       = srch_right ? r_hi : {1'b0, r_mid};
        srch_mid   = n_lo + ((n_hi - n_lo) >> 1);
        srch_more  = (n_lo < n_hi);
        if (n_lo >= r_count) begin
            srch_sel = IDX_W'(r_count - CNT_W'(1));
        end else begin
            srch_sel = n_lo[IDX_W-1:0];
        end
    end

    // RAM write on an accepted append, read address by state
    always_comb begin
        ram_we = req_xfer && (req_cmd == CMD_APPEND) && !tbl_full;
        case (r_state)
            S_IDLE: begin
                if (req_cmd == CMD_INDEX) begin
                    ram_raddr = i_req.entry_index;
                end else begin
                    ram_raddr = IDX_W'(r_count >> 1);
                end
            end
            S_SRCH:  ram_raddr = srch_more ? srch_mid[IDX_W-1:0] : srch_sel;
            S_SEL:   ram_raddr = r_sel - IDX_W'(1);
            default: ram_raddr = r_mid;
        endcase
    end

    ntft_ram #(
        .WIDTH (TIME_BITS),
        .DEPTH (TABLE_DEPTH)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_count[IDX_W-1:0]),
        .i_wdata (i_req.time_value),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    // command sequencer and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_count   <= '0;
            r_o_valid <= 1'b0;
        end else begin
            // output valid: set on load, cleared on transfer
            if (rsp_load) begin
                r_o_valid <= 1'b1;
            end else if (r_o_valid && o_rsp.ready) begin
                r_o_valid <= 1'b0;
            end

            unique case (r_state)
                S_IDLE: begin
                    if (req_xfer) begin
                        unique case (req_cmd)
                            CMD_APPEND: begin
                                r_state <= S_DONE;
                                if (tbl_full) begin
                                    r_st_status <= ST_FULL;
                                    r_st_idx    <= '0;
                                    r_st_time   <= '0;
                                end else begin
                                    r_st_status <= ST_OK;
                                    r_st_idx    <= r_count[IDX_W-1:0];
                                    r_st_time   <= i_req.time_value;
                                    r_last      <= i_req.time_value;
                                    if (r_count == '0) begin
                                        r_first <= i_req.time_value;
                                    end
                                    r_count <= r_count + CNT_W'(1);
                                end
                            end
                            CMD_CLEAR: begin
                                r_st_status <= ST_OK;
                                r_st_idx    <= '0;
                                r_st_time   <= '0;
                                r_count     <= '0;
                                r_state     <= S_DONE;
                            end
                            CMD_TIME: begin
                                r_st_status <= ST_OK;
                                if (r_count == '0) begin
                                    r_st_status <= ST_NOT_FOUND;
                                    r_st_idx    <= '0;
                                    r_st_time   <= '0;
                                    r_state     <= S_DONE;
                                end else if (i_req.time_value < r_first) begin
                                    r_st_idx  <= '0;
                                    r_st_time <= r_first;
                                    r_state   <= S_DONE;
                                end else if (i_req.time_value >= r_last) begin
                                    r_st_idx  <= IDX_W'(r_count - CNT_W'(1));
                                    r_st_time <= r_last;
                                    r_state   <= S_DONE;
                                end else begin
                                    r_q     <= i_req.time_value;
                                    r_lo    <= '0;
                                    r_hi    <= r_count;
                                    r_mid   <= IDX_W'(r_count >> 1);
                                    r_state <= S_SRCH;
                                end
                            end
                            CMD_INDEX: begin
                                if ({1'b0, i_req.entry_index} >= r_count) begin
                                    r_st_status <= ST_NOT_FOUND;
                                    r_st_idx    <= '0;
                                    r_st_time   <= '0;
                                    r_state     <= S_DONE;
                                end else begin
                                    r_st_status <= ST_OK;
                                    r_sel       <= i_req.entry_index;
                                    r_state     <= S_IDX;
                                end
                            end
                        endcase
                    end
                end
                S_IDX: begin
                    r_st_idx  <= r_sel;
                    r_st_time <= ram_rdata;
                    r_state   <= S_DONE;
                end
                S_SRCH: begin
                    r_lo  <= n_lo;
                    r_hi  <= n_hi;
                    r_mid <= srch_mid[IDX_W-1:0];
                    if (!srch_more) begin
                        r_sel   <= srch_sel;
                        r_state <= S_SEL;
                    end
                end
                S_SEL: begin
                    r_tsel <= ram_rdata;
                    if (r_sel == '0) begin
                        r_st_idx  <= '0;
                        r_st_time <= ram_rdata;
                        r_state   <= S_DONE;
                    end else begin
                        r_state <= S_PREV;
                    end
                end
                S_PREV: begin
                    // absolute distances of both neighbours to the query
                    r_tprev <= ram_rdata;
                    r_dprev <= (r_q >= ram_rdata) ? (r_q - ram_rdata) : (ram_rdata - r_q);
                    r_dsel  <= (r_tsel >= r_q) ? (r_tsel - r_q) : (r_q - r_tsel);
                    r_state <= S_PICK;
                end
                S_PICK: begin
                    // earlier neighbour only when strictly closer
                    if (r_dprev < r_dsel) begin
                        r_st_idx  <= r_sel - IDX_W'(1);
                        r_st_time <= r_tprev;
                    end else begin
                        r_st_idx  <= r_sel;
                        r_st_time <= r_tsel;
                    end
                    r_state <= S_DONE;
                end
                S_DONE: begin
                    if (out_free) begin
                        r_o_status <= r_st_status;
                        r_o_idx    <= r_st_idx;
                        r_o_time   <= r_st_time;
                        r_o_count  <= r_count;
                        r_o_dur    <= (r_count == '0) ? '0 : r_last;
                        r_state    <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_rsp.valid       = r_o_valid;
    assign o_rsp.status      = r_o_status;
    assign o_rsp.found_index = r_o_idx;
    assign o_rsp.found_time  = r_o_time;
    assign o_rsp.entry_count = r_o_count;
    assign o_rsp.duration    = r_o_dur;

endmodule

`default_nettype wire

>>> dv/tb_nearest_timestamp_frame_table_top.sv
// Testbench for the nearest-timestamp frame table: directed table, then random mix.
`timescale 1ns / 1ps

module tb_nearest_timestamp_frame_table_top
    import ntft_pkg::*;
();

    // One response of the table, as the output channel carries it
    typedef struct packed {
        t_status              status;
        logic [IDX_W-1:0]     found_index;
        logic [TIME_BITS-1:0] found_time;
        logic [CNT_W-1:0]     entry_count;
        logic [TIME_BITS-1:0] duration;
    } t_frame_result;

    // Directed stimulus row; want is used only where typed is set
    typedef struct packed {
        t_cmd                 cmd;
        logic [TIME_BITS-1:0] time_value;
        logic [IDX_W-1:0]     entry_index;
        logic                 typed;
        t_frame_result        want;
    } t_probe_row;

    localparam t_frame_result NO_WANT = '0;
    localparam int PROBE_ROWS = 26;

    logic i_clk;
    logic i_rst_n;

    ntft_req_if req_ch ();
    ntft_rsp_if rsp_ch ();

    nearest_timestamp_frame_table_top uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_ch),
        .o_rsp   (rsp_ch)
    );

    // Shadow copy of the table held by the predictor
    logic [TIME_BITS-1:0] stamp_mem [TABLE_DEPTH];
    int                   stamp_count = 0;

    t_frame_result pending_results [$];
    int            mismatch_count = 0;
    int            send_idle_pct  = 19;
    int            recv_idle_pct  = 69;
    int            rsp_holdoff    = 0;

    t_probe_row probe_table [PROBE_ROWS] = '{
        // empty table after reset
        '{CMD_TIME,  32'd0,          10'd0,    1'b1, '{ST_NOT_FOUND, 10'd0, 32'd0, 11'd0, 32'd0}},
        '{CMD_TIME,  32'hFFFF_FFFF,  10'd0,    1'b1, '{ST_NOT_FOUND, 10'd0, 32'd0, 11'd0, 32'd0}},
        '{CMD_INDEX, 32'd0,          10'd0,    1'b1, '{ST_NOT_FOUND, 10'd0, 32'd0, 11'd0, 32'd0}},
        '{CMD_INDEX, 32'hFFFF_FFFF,  10'd1023, 1'b1, '{ST_NOT_FOUND, 10'd0, 32'd0, 11'd0, 32'd0}},
        '{CMD_CLEAR, 32'd0,          10'd0,    1'b1, '{ST_OK, 10'd0, 32'd0, 11'd0, 32'd0}},
        // single entry: any query lands on it
        '{CMD_APPEND, 32'd10,        10'd0,    1'b1, '{ST_OK, 10'd0, 32'd10, 11'd1, 32'd10}},
        '{CMD_TIME,  32'hFFFF_FFFF,  10'd0,    1'b1, '{ST_OK, 10'd0, 32'd10, 11'd1, 32'd10}},
        '{CMD_APPEND, 32'd100,       10'd0,    1'b1, '{ST_OK, 10'd1, 32'd100, 11'd2, 32'd100}},
        '{CMD_APPEND, 32'd200,       10'd0,    1'b1, '{ST_OK, 10'd2, 32'd200, 11'd3, 32'd200}},
        '{CMD_APPEND, 32'd200,       10'd0,    1'b1, '{ST_OK, 10'd3, 32'd200, 11'd4, 32'd200}},
        '{CMD_APPEND, 32'd300,       10'd0,    1'b1, '{ST_OK, 10'd4, 32'd300, 11'd5, 32'd300}},
        // clamps at both ends
        '{CMD_TIME,  32'd0,          10'd0,    1'b1, '{ST_OK, 10'd0, 32'd10, 11'd5, 32'd300}},
        '{CMD_TIME,  32'hFFFF_FFFF,  10'd0,    1'b1, '{ST_OK, 10'd4, 32'd300, 11'd5, 32'd300}},
        // tie goes to the later entry, earlier only when strictly closer, duplicates
        '{CMD_TIME,  32'd150,        10'd0,    1'b0, NO_WANT},
        '{CMD_TIME,  32'd149,        10'd0,    1'b0, NO_WANT},
        '{CMD_TIME,  32'd200,        10'd0,    1'b0, NO_WANT},
        '{CMD_INDEX, 32'd0,          10'd4,    1'b0, NO_WANT},
        '{CMD_INDEX, 32'd0,          10'd5,    1'b1, '{ST_NOT_FOUND, 10'd0, 32'd0, 11'd5, 32'd300}},
        '{CMD_INDEX, 32'd0,          10'd1023, 1'b1, '{ST_NOT_FOUND, 10'd0, 32'd0, 11'd5, 32'd300}},
        // out-of-order append, then search on an unsorted table
        '{CMD_APPEND, 32'd50,        10'd0,    1'b1, '{ST_OK, 10'd5, 32'd50, 11'd6, 32'd50}},
        '{CMD_TIME,  32'd120,        10'd0,    1'b0, NO_WANT},
        '{CMD_APPEND, 32'hFFFF_FFFF, 10'd0,    1'b1,
            '{ST_OK, 10'd6, 32'hFFFF_FFFF, 11'd7, 32'hFFFF_FFFF}},
        '{CMD_TIME,  32'd250,        10'd0,    1'b0, NO_WANT},
        // clear keeps contents but hides them
        '{CMD_CLEAR, 32'd0,          10'd0,    1'b1, '{ST_OK, 10'd0, 32'd0, 11'd0, 32'd0}},
        '{CMD_INDEX, 32'd0,          10'd0,    1'b1, '{ST_NOT_FOUND, 10'd0, 32'd0, 11'd0, 32'd0}},
        '{CMD_APPEND, 32'd0,         10'd0,    1'b1, '{ST_OK, 10'd0, 32'd0, 11'd1, 32'd0}}
    };

    // Clock
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Hard stop in case the block hangs
    initial begin
        #5_000_000;
        $display("nearest_timestamp_frame_table_top test failed");
        $finish;
    end

    // Nearest slot to a query: clamp, then lower-bound search and neighbour compare
    function automatic int nearest_stamp_slot(logic [TIME_BITS-1:0] query);
        int                   lo;
        int                   hi;
        int                   mid;
        int                   pick;
        logic [TIME_BITS-1:0] gap_prev;
        logic [TIME_BITS-1:0] gap_pick;
        lo = 0;
        hi = stamp_count;
        if (query < stamp_mem[0]) return 0;
        if (query >= stamp_mem[stamp_count-1]) return stamp_count - 1;
        while (lo < hi) begin
            mid = lo + (hi - lo) / 2;
            if (stamp_mem[mid] < query) lo = mid + 1;
            else hi = mid;
        end
        pick = (lo >= stamp_count) ? stamp_count - 1 : lo;
        if (pick != 0) begin
            gap_prev = (query >= stamp_mem[pick-1]) ? query - stamp_mem[pick-1]
                                                    : stamp_mem[pick-1] - query;
            gap_pick = (stamp_mem[pick] >= query) ? stamp_mem[pick] - query
                                                  : query - stamp_mem[pick];
            if (gap_prev < gap_pick) pick = pick - 1;
        end
        return pick;
    endfunction

    // Apply one command to the shadow table and return the response it yields
    function automatic t_frame_result table_apply(t_cmd cmd, logic [TIME_BITS-1:0] tv,
                                                  logic [IDX_W-1:0] idx);
        t_frame_result res;
        int            slot;
        res = '0;
        res.status = ST_OK;
        case (cmd)
            CMD_APPEND: begin
                if (stamp_count >= TABLE_DEPTH) begin
                    res.status = ST_FULL;
                end else begin
                    stamp_mem[stamp_count] = tv;
                    res.found_index = IDX_W'(stamp_count);
                    res.found_time  = tv;
                    stamp_count++;
                end
            end
            CMD_CLEAR: begin
                stamp_count = 0;
            end
            CMD_TIME: begin
                if (stamp_count == 0) begin
                    res.status = ST_NOT_FOUND;
                end else begin
                    slot = nearest_stamp_slot(tv);
                    res.found_index = IDX_W'(slot);
                    res.found_time  = stamp_mem[slot];
                end
            end
            default: begin
                if (int'(idx) >= stamp_count) begin
                    res.status = ST_NOT_FOUND;
                end else begin
                    res.found_index = idx;
                    res.found_time  = stamp_mem[idx];
                end
            end
        endcase
        res.entry_count = CNT_W'(stamp_count);
        res.duration    = (stamp_count != 0) ? stamp_mem[stamp_count-1] : '0;
        return res;
    endfunction

    // Query near a stored entry, between two entries, or anywhere
    function automatic logic [TIME_BITS-1:0] pick_query();
        int                   s;
        logic [TIME_BITS-1:0] q;
        if (stamp_count == 0 || $urandom_range(4) == 0) return $urandom();
        s = $urandom_range(stamp_count - 1);
        case ($urandom_range(3))
            0: q = stamp_mem[s];
            1: q = stamp_mem[s] + $urandom_range(3);
            2: q = stamp_mem[s] - $urandom_range(3);
            default: begin
                if (s + 1 < stamp_count)
                    q = stamp_mem[s] + (stamp_mem[s+1] - stamp_mem[s]) / 2;
                else
                    q = stamp_mem[s] + 1;
            end
        endcase
        return q;
    endfunction

    // Offer one command; on transfer, predict and queue the expected response
    task automatic offer_command(t_cmd cmd, logic [TIME_BITS-1:0] tv, logic [IDX_W-1:0] idx,
                                 logic typed = 1'b0, t_frame_result want = '0);
        t_frame_result res;
        while ($urandom_range(99) < send_idle_pct) begin
            req_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        req_ch.valid       <= 1'b1;
        req_ch.command     <= cmd;
        req_ch.time_value  <= tv;
        req_ch.entry_index <= idx;
        @(posedge i_clk);
        while (!req_ch.ready) @(posedge i_clk);
        res = table_apply(cmd, tv, idx);
        if (typed) res = want;
        pending_results = {pending_results, res};
    endtask

    // Stop offering until every expected response has arrived
    task automatic wait_drained();
        req_ch.valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
    endtask

    // Mostly ordered appends with lookups, some clears and out-of-order values
    task automatic run_random_mix(int n_items);
        int                   roll;
        logic [TIME_BITS-1:0] stamp;
        logic [TIME_BITS-1:0] step;
        logic [IDX_W-1:0]     slot;
        repeat (n_items) begin
            roll = $urandom_range(99);
            if (roll < 4) begin
                offer_command(CMD_CLEAR, $urandom(), IDX_W'($urandom()));
            end else if (roll < 45) begin
                if (stamp_count == 0 || $urandom_range(15) == 0) begin
                    // fresh base, or a value that breaks the ordering
                    stamp = $urandom_range(1) ? $urandom() : $urandom_range(1000);
                end else begin
                    case ($urandom_range(7))
                        0:       step = '0;
                        1:       step = $urandom() >> 8;
                        default: step = $urandom_range(1, 100000);
                    endcase
                    stamp = stamp_mem[stamp_count-1] + step;
                    if (stamp < step) stamp = '1;   // saturate on wrap
                end
                offer_command(CMD_APPEND, stamp, IDX_W'($urandom()));
            end else if (roll < 85) begin
                offer_command(CMD_TIME, pick_query(), IDX_W'($urandom()));
            end else begin
                if ($urandom_range(3) == 0) slot = IDX_W'($urandom());
                else slot = IDX_W'($urandom_range(stamp_count));
                offer_command(CMD_INDEX, $urandom(), slot);
            end
        end
    endtask

    // Response side: check each transfer, then choose ready for the next cycle
    initial begin
        t_frame_result want;
        rsp_ch.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (rsp_ch.valid && rsp_ch.ready) begin
                if (pending_results.size() == 0) begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("ERROR: response with none expected: st=%0d idx=%0d t=%0h",
                                 rsp_ch.status, rsp_ch.found_index, rsp_ch.found_time);
                end else begin
                    want = pending_results.pop_front();
                    if (rsp_ch.status !== want.status ||
                        rsp_ch.found_index !== want.found_index ||
                        rsp_ch.found_time !== want.found_time ||
                        rsp_ch.entry_count !== want.entry_count ||
                        rsp_ch.duration !== want.duration) begin
                        mismatch_count++;
                        if (mismatch_count <= 10) begin
                            $display("ERROR: exp st=%0d idx=%0d t=%0h cnt=%0d dur=%0h",
                                     want.status, want.found_index, want.found_time,
                                     want.entry_count, want.duration);
                            $display("       got st=%0d idx=%0d t=%0h cnt=%0d dur=%0h",
                                     rsp_ch.status, rsp_ch.found_index, rsp_ch.found_time,
                                     rsp_ch.entry_count, rsp_ch.duration);
                        end
                    end
                end
            end
            if (rsp_holdoff > 0) begin
                rsp_ch.ready <= 1'b0;
                rsp_holdoff--;
            end else begin
                rsp_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
            end
        end
    end

    // Main sequence
    initial begin
        i_rst_n            <= 1'b0;
        req_ch.valid       <= 1'b0;
        req_ch.command     <= CMD_APPEND;
        req_ch.time_value  <= '0;
        req_ch.entry_index <= '0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed rows, then random with sender and receiver idling
        foreach (probe_table[r])
            offer_command(probe_table[r].cmd, probe_table[r].time_value,
                          probe_table[r].entry_index, probe_table[r].typed,
                          probe_table[r].want);
        run_random_mix(125);
        wait_drained();

        send_idle_pct = 69;
        recv_idle_pct = 19;
        run_random_mix(125);
        wait_drained();

        // no idling; receiver holds off long enough to back up the input
        send_idle_pct = 0;
        recv_idle_pct = 0;
        rsp_holdoff   = 300;
        run_random_mix(124);

        wait_drained();
        repeat (30) @(posedge i_clk);
        if (mismatch_count == 0 && pending_results.size() == 0)
            $display("nearest_timestamp_frame_table_top test passed");
        else
            $display("nearest_timestamp_frame_table_top test failed");
        $finish;
    end

endmodule
